### rtl/core/u8dc_pkg.sv
package u8dc_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int CODE_W = 16;
   localparam int SLOT_W = 10;
   localparam int BYTE_W = 8;

   localparam logic [CODE_W-1:0] KEEP_ABOVE_RESET = 16'h007E;

   // packed result layout
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_OUT
   } state_type;

endpackage

### rtl/core/utf8_decode_unique_collector_unit.sv
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | req_tdata[7:0] text_byte
// rsp     | out | rsp_tvalid/rsp_tready | tdata code_point, slot; tuser is_new, dropped
// csr     | in  | csr_we                | csr_wdata[15:0] keep_above
//
// a byte that completes no collected code is taken without leaving ST_IDLE
// a collected code is searched with one table read and compare per stored entry
// through the single read port before its result goes to ST_OUT
// synchronous reset clears decoder state, entry count and halt; table contents stay
// the result sits in an output register; bytes are taken while it waits, but a
// second finished search holds in ST_OUT until the register frees
module utf8_decode_unique_collector_unit
   import u8dc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] text_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] code_point, [25:16] slot, zero fill
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [0] is_new, [1] dropped
   input  logic                  csr_we,
   input  logic [CODE_W-1:0]     csr_wdata
);

   state_type state_ff, state_in;

   logic [CODE_W-1:0] keep_above_ff;
   logic [1:0]        pending_ff, pending_in;
   logic [CODE_W-1:0] partial_ff, partial_in;
   logic              halted_ff, halted_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [CODE_W-1:0] code_ff, code_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cmp_ff, cmp_in;
   logic              pend_ff, pend_in;

   logic [CODE_W-1:0] res_code_ff, res_code_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              res_new_ff, res_new_in;
   logic              res_drop_ff, res_drop_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] out_code_ff, out_code_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic              out_new_ff, out_new_in;
   logic              out_drop_ff, out_drop_in;

   logic              ram_we;
   logic [CODE_W-1:0] ram_q;

   logic              accept;
   logic              hit;
   logic              more;
   logic              miss;
   logic              full;
   logic [CODE_W-1:0] cont_code;
   logic [CODE_W-1:0] done_code;
   logic              done_valid;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign hit        = pend_ff && (ram_q == code_ff);
   assign more       = idx_ff < count_ff;
   assign miss       = (state_ff == ST_SEARCH) && !hit && !more;
   assign full       = count_ff == CNT_W'(TABLE_DEPTH);
   assign cont_code  = {partial_ff[CODE_W-7:0], req_tdata[5:0]};
   assign ram_we     = miss && !full;

   u8dc_ram #(
      .WIDTH (CODE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (code_ff),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         keep_above_ff <= KEEP_ABOVE_RESET;
         pending_ff    <= '0;
         partial_ff    <= '0;
         halted_ff     <= 1'b0;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         partial_ff   <= partial_in;
         halted_ff    <= halted_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            keep_above_ff <= csr_wdata;
         end
      end
      code_ff     <= code_in;
      idx_ff      <= idx_in;
      cmp_ff      <= cmp_in;
      res_code_ff <= res_code_in;
      res_slot_ff <= res_slot_in;
      res_new_ff  <= res_new_in;
      res_drop_ff <= res_drop_in;
      out_code_ff <= out_code_in;
      out_slot_ff <= out_slot_in;
      out_new_ff  <= out_new_in;
      out_drop_ff <= out_drop_in;
   end

   // byte decode
   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      halted_in  = halted_ff;
      done_code  = '0;
      done_valid = 1'b0;
      if (accept && !halted_ff) begin
         if (req_tdata == '0) begin
            halted_in  = 1'b1;
            pending_in = '0;
            partial_in = '0;
         end else if (pending_ff != 2'd0) begin
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               partial_in = '0;
               done_code  = cont_code;
               done_valid = 1'b1;
            end else begin
               partial_in = cont_code;
            end
         end else if (!req_tdata[7]) begin
            done_code  = CODE_W'(req_tdata);
            done_valid = 1'b1;
         end else if (req_tdata[7:5] == 3'b110) begin
            partial_in = CODE_W'(req_tdata[4:0]);
            pending_in = 2'd1;
         end else if (req_tdata[7:4] == 4'b1110) begin
            partial_in = CODE_W'(req_tdata[3:0]);
            pending_in = 2'd2;
         end
      end
   end

   // sequencer: search, append, hand to output register
   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      idx_in       = idx_ff;
      cmp_in       = cmp_ff;
      pend_in      = 1'b0;
      count_in     = count_ff;
      res_code_in  = res_code_ff;
      res_slot_in  = res_slot_ff;
      res_new_in   = res_new_ff;
      res_drop_in  = res_drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_code_in  = out_code_ff;
      out_slot_in  = out_slot_ff;
      out_new_in   = out_new_ff;
      out_drop_in  = out_drop_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (done_valid && (done_code > keep_above_ff)) begin
               code_in  = done_code;
               idx_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            res_code_in = code_ff;
            if (hit) begin
               res_slot_in = SLOT_W'(32'(cmp_ff));
               res_new_in  = 1'b0;
               res_drop_in = 1'b0;
               state_in    = ST_OUT;
            end else if (more) begin
               pend_in = 1'b1;
               cmp_in  = idx_ff;
               idx_in  = idx_ff + CNT_W'(1);
            end else if (full) begin
               res_slot_in = '0;
               res_new_in  = 1'b0;
               res_drop_in = 1'b1;
               state_in    = ST_OUT;
            end else begin
               res_slot_in = SLOT_W'(32'(count_ff));
               res_new_in  = 1'b1;
               res_drop_in = 1'b0;
               count_in    = count_ff + CNT_W'(1);
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_code_in  = res_code_ff;
               out_slot_in  = res_slot_ff;
               out_new_in   = res_new_ff;
               out_drop_in  = res_drop_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SLOT_W - CODE_W){1'b0}}, out_slot_ff, out_code_ff};
   assign rsp_tuser  = {out_drop_ff, out_new_ff};

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && pend_ff) |-> (cmp_ff < count_ff))
      else $error("compare of an unfilled slot");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (count_ff == $past(count_ff) + CNT_W'(1)) && res_new_ff)
      else $error("append without count step");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt released without reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (halted_ff && state_ff == ST_IDLE) |=> state_ff == ST_IDLE)
      else $error("search started while halted");
`endif

endmodule

### rtl/core/u8dc_ram.sv
module u8dc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/tb.sv
module tb;
   import u8dc_pkg::*;

   localparam logic [7:0] LEAD2_PFX = 8'hC0;
   localparam logic [7:0] LEAD3_PFX = 8'hE0;
   localparam logic [7:0] CONT_PFX  = 8'h80;
   localparam logic [7:0] HALT_BYTE = 8'h00;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         STALL_LIMIT   = 8000;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              is_new;
      logic [SLOT_W-1:0] slot;
      logic              dropped;
   } collect_result_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CODE_W-1:0]     csr_wdata = '0;

   // decoder and collector state as predicted
   logic [1:0]        dec_pend;
   logic [CODE_W-1:0] dec_part;
   logic [CODE_W-1:0] code_tbl [TABLE_DEPTH];
   int                tbl_count;
   bit                dec_halted;
   logic [CODE_W-1:0] keep_above;

   collect_result_type collected_q[$];
   logic [CODE_W-1:0] recent_codes[$];

   int  mismatch_count = 0;
   int  results_checked = 0;
   int  bytes_sent;
   int  burst_left;
   bit  send_gaps;
   bit  rsp_stalls;
   int  idle_cycles = 0;

   utf8_decode_unique_collector_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int find_code(input logic [CODE_W-1:0] cp);
      for (int i = 0; i < tbl_count; i++) begin
         if (code_tbl[i] == cp) return i;
      end
      return -1;
   endfunction

   function automatic void decode_and_collect(input logic [7:0] b);
      logic [CODE_W-1:0]  cp;
      bit                 done;
      int                 hit;
      collect_result_type r;
      if (dec_halted) return;
      if (b == HALT_BYTE) begin
         dec_halted = 1'b1;
         dec_pend   = '0;
         dec_part   = '0;
         return;
      end
      done = 1'b0;
      cp   = '0;
      if (dec_pend != 0) begin
         // continuation bytes are not checked, only their low six bits count
         dec_part = {dec_part[9:0], b[5:0]};
         dec_pend = dec_pend - 2'd1;
         if (dec_pend == 0) begin
            cp       = dec_part;
            dec_part = '0;
            done     = 1'b1;
         end
      end else if (!b[7]) begin
         cp   = {8'h00, b};
         done = 1'b1;
      end else if ((b & 8'hE0) == LEAD2_PFX) begin
         dec_part = {11'd0, b[4:0]};
         dec_pend = 2'd1;
      end else if ((b & 8'hF0) == LEAD3_PFX) begin
         dec_part = {12'd0, b[3:0]};
         dec_pend = 2'd2;
      end
      if (!done || cp <= keep_above) return;
      hit     = find_code(cp);
      r.code  = cp;
      if (hit >= 0) begin
         r.is_new  = 1'b0;
         r.slot    = hit[SLOT_W-1:0];
         r.dropped = 1'b0;
      end else if (tbl_count < TABLE_DEPTH) begin
         code_tbl[tbl_count] = cp;
         r.is_new  = 1'b1;
         r.slot    = tbl_count[SLOT_W-1:0];
         r.dropped = 1'b0;
         tbl_count++;
      end else begin
         r.is_new  = 1'b0;
         r.slot    = '0;
         r.dropped = 1'b1;
      end
      collected_q.push_back(r);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (send_gaps && burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      bytes_sent++;
      decode_and_collect(b);
   endtask

   function automatic int natural_len(input logic [CODE_W-1:0] cp);
      if (cp == 0) return 2;
      if (cp < 16'h0080) return 1;
      if (cp < 16'h0800) return 2;
      return 3;
   endfunction

   task automatic send_code(input logic [CODE_W-1:0] cp, input int len);
      recent_codes.push_back(cp);
      if (recent_codes.size() > 24) void'(recent_codes.pop_front());
      case (len)
         1: send_byte(cp[7:0]);
         2: begin
            send_byte(LEAD2_PFX | {3'b000, cp[10:6]});
            send_byte(CONT_PFX | {2'b00, cp[5:0]});
         end
         default: begin
            send_byte(LEAD3_PFX | {4'b0000, cp[15:12]});
            send_byte(CONT_PFX | {2'b00, cp[11:6]});
            send_byte(CONT_PFX | {2'b00, cp[5:0]});
         end
      endcase
   endtask

   // let every expected result arrive, then give a byte still in flight time to finish
   task automatic settle_block();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (collected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep_above(input logic [CODE_W-1:0] value);
      settle_block();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      keep_above = value;
   endtask

   task automatic send_bytes(input logic [7:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // reset threshold, all three sequence lengths, repeats, stray leads, unchecked continuations
   task automatic test_sequence_forms();
      send_bytes('{8'h7E, 8'h7F, 8'hC2, 8'h80, 8'h7F, 8'hEF, 8'hBF, 8'hBF,
                   8'h80, 8'hF5, 8'hFF, 8'hC3, 8'h41, 8'hE1, 8'hFF, 8'h7F,
                   8'hC1, 8'hBF});
      settle_block();
   endtask

   task automatic test_threshold_extremes();
      write_keep_above(16'hFFFF);
      send_bytes('{8'hEF, 8'hBF, 8'hBF});
      write_keep_above(16'h0000);
      send_bytes('{8'h01, 8'hC0, 8'h80});
      write_keep_above(16'h07FF);
      send_bytes('{8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80});
      settle_block();
   endtask

   task automatic test_random_text(input logic [CODE_W-1:0] thresh, input int n_items,
                                   input bit idling);
      int                counted;
      int                pick;
      int                len;
      int                n_cont;
      logic [CODE_W-1:0] cp;
      write_keep_above(thresh);
      send_gaps  = idling;
      rsp_stalls = idling;
      counted    = 0;
      while (counted < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if (recent_codes.size() > 0 && $urandom_range(0, 9) < 4) begin
               cp = recent_codes[$urandom_range(0, recent_codes.size() - 1)];
            end else begin
               case ($urandom_range(0, 2))
                  0: cp = 16'($urandom_range(1, 16'h007F));
                  1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                  default: cp = 16'($urandom_range(0, 16'hFFFF));
               endcase
            end
            len = natural_len(cp);
            // overlong forms decode the same way
            if (len < 3 && $urandom_range(0, 9) == 0) len = 3;
            send_code(cp, len);
            counted += len;
         end else if (pick < 88) begin
            // lead byte followed by arbitrary nonzero bytes, also other leads
            if ($urandom_range(0, 1) == 0) begin
               send_byte(LEAD2_PFX | 8'($urandom_range(0, 31)));
               n_cont = 1;
            end else begin
               send_byte(LEAD3_PFX | 8'($urandom_range(0, 15)));
               n_cont = 2;
            end
            repeat (n_cont) send_byte(8'($urandom_range(1, 255)));
            counted += n_cont + 1;
         end else begin
            // stray continuation or unknown lead, ignored by the decoder
            if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(8'h80, 8'hBF)));
            else send_byte(8'($urandom_range(8'hF0, 8'hFF)));
         end
      end
      settle_block();
      send_gaps  = 1'b1;
      rsp_stalls = 1'b1;
   endtask

   task automatic test_table_full();
      logic [CODE_W-1:0] cand;
      write_keep_above(16'h0000);
      cand = 16'h0800;
      while (tbl_count < TABLE_DEPTH) begin
         if (find_code(cand) < 0) send_code(cand, 3);
         cand++;
      end
      while (find_code(cand) >= 0) cand++;
      // new codes are dropped, stored ones are still found
      send_code(cand, 3);
      send_code(code_tbl[TABLE_DEPTH-1], natural_len(code_tbl[TABLE_DEPTH-1]));
      send_code(code_tbl[0], natural_len(code_tbl[0]));
      send_code(code_tbl[TABLE_DEPTH/2], 3);
      send_code(cand + 16'd1, 3);
      settle_block();
   endtask

   // zero byte drops the open sequence and everything after is ignored
   task automatic test_halt();
      send_bytes('{8'hE2, 8'h82, HALT_BYTE, 8'hAC, 8'h41, 8'hC3, 8'hA9, 8'h7F,
                   8'hEF, 8'hBF, 8'hBF, 8'hFF});
      settle_block();
   endtask

   always @(posedge clock) begin : check_results
      static int run_left = 0;
      static bit ready_phase = 1'b1;
      collect_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (collected_q.size() == 0) begin
            $error("result with no expectation: code_point %h", rsp_tdata[15:0]);
            mismatch_count++;
         end else begin
            want = collected_q.pop_front();
            if (rsp_tdata[15:0] !== want.code) begin
               $error("code_point: expected %h, got %h", want.code, rsp_tdata[15:0]);
               mismatch_count++;
            end
            if (rsp_tdata[25:16] !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_tdata[25:16]);
               mismatch_count++;
            end
            if (rsp_tuser[0] !== want.is_new) begin
               $error("is_new: expected %b, got %b", want.is_new, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tuser[1] !== want.dropped) begin
               $error("dropped: expected %b, got %b", want.dropped, rsp_tuser[1]);
               mismatch_count++;
            end
         end
      end
      if (reset || !rsp_stalls) begin
         rsp_tready <= !reset;
      end else begin
         if (run_left == 0) begin
            ready_phase = ~ready_phase;
            run_left    = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 4);
         end
         run_left--;
         rsp_tready <= ready_phase;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      dec_pend        = '0;
      dec_part        = '0;
      tbl_count       = 0;
      dec_halted      = 1'b0;
      keep_above      = KEEP_ABOVE_RESET;
      bytes_sent      = 0;
      burst_left      = 0;
      send_gaps       = 1'b1;
      rsp_stalls      = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sequence_forms();
      test_threshold_extremes();
      test_random_text(KEEP_ABOVE_RESET, 145, 1'b1);
      test_random_text(16'h0000, 145, 1'b0);
      test_random_text(16'($urandom_range(16'h0080, 16'hFFFE)), 145, 1'b1);
      test_random_text(16'($urandom_range(0, 16'h07FF)), 145, 1'b1);
      test_table_full();
      test_halt();

      repeat (20) @(posedge clock);
      if (collected_q.size() != 0) begin
         $error("%0d expected results never arrived", collected_q.size());
      end
      $display("sent %0d bytes of text over several thresholds, checked %0d results",
               bytes_sent, results_checked);
      $display("table reached %0d entries, then overflow and halt were exercised", tbl_count);
      if (mismatch_count == 0 && collected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### utf8_decode_unique_collector_unit.f
rtl/core/u8dc_pkg.sv
rtl/core/u8dc_ram.sv
rtl/core/utf8_decode_unique_collector_unit.sv
tb/tb.sv
